/* src/lag_pkg.sv */
// Shared types and constants for the life automaton grid step block.
package lag_pkg;

  localparam int unsigned SIZE_W    = 9;  // holds any grid size up to 256
  localparam int unsigned ADDR_W    = 5;  // row and col fields of an input beat
  localparam int unsigned OP_W      = 2;
  localparam int unsigned CFG_W     = 6;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_GEN   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

  localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 6'd20;

  typedef struct packed {
    logic cell_we;    // single-cell write into the active bank
    logic cell_re;    // single-cell read issue on the active bank
    logic gen_start;  // clear window, invalidate the inactive bank
    logic gen_re;     // generation row read from the active bank
    logic gen_use;    // read data of this cycle feeds the window
    logic gen_we;     // write computed row into the inactive bank
    logic gen_shift;  // advance the three-row window
    logic out_load;   // move read result into the output register
    logic flip;       // swap active bank
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

/* src/life_automaton_grid_step_top.sv */
// Write beat: back to back. Read beat: the bank row is registered at acceptance, and the
// result register loads once the output is free, the input stalling until then.
// Generation beat: input stalls until the banks flip after the last row write, bounded
// by the single row-wide read port of each grid bank (one row per cycle, row of lanes).
// Reset: both banks read as dead at once via per-row valid bits (no clearing pass),
// bank a active, rows_in_use and cols_in_use set to 20.
module life_automaton_grid_step_top #(
  parameter int unsigned MAX_ROWS = 32,
  parameter int unsigned MAX_COLS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [lag_pkg::OP_W-1:0]          opcode_i,
  input  logic [lag_pkg::ADDR_W-1:0]        row_i,
  input  logic [lag_pkg::ADDR_W-1:0]        col_i,
  input  logic                              cell_in_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              cell_out_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lag_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [lag_pkg::CFG_W-1:0]         cfg_data_i
);

  localparam int unsigned RW  = $clog2(MAX_ROWS);
  localparam int unsigned NRW = $clog2(MAX_ROWS + 1);
  localparam int unsigned NCW = $clog2(MAX_COLS + 1);

  logic [NRW-1:0] nr;
  logic [NCW-1:0] nc;
  lag_pkg::cmd_t  cmd;
  lag_pkg::sts_t  sts;
  logic [RW-1:0]  gen_rd_row, gen_wr_row;

  lag_cfg #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .nr_o        (nr),
    .nc_o        (nc)
  );

  lag_ctrl #(
    .MAX_ROWS (MAX_ROWS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .nr_i         (nr),
    .sts_i        (sts),
    .cmd_o        (cmd),
    .gen_rd_row_o (gen_rd_row),
    .gen_wr_row_o (gen_wr_row)
  );

  lag_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .gen_rd_row_i (gen_rd_row),
    .gen_wr_row_i (gen_wr_row),
    .nc_i         (nc),
    .row_i        (row_i),
    .col_i        (col_i),
    .cell_in_i    (cell_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .cell_out_o   (cell_out_o)
  );

endmodule

/* src/lag_cfg.sv */
// Configuration registers and clamped region size.
module lag_cfg #(
  parameter int unsigned MAX_ROWS = 32,
  parameter int unsigned MAX_COLS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lag_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [lag_pkg::CFG_W-1:0]         cfg_data_i,
  output logic [$clog2(MAX_ROWS+1)-1:0]     nr_o,
  output logic [$clog2(MAX_COLS+1)-1:0]     nc_o
);

  localparam int unsigned NRW = $clog2(MAX_ROWS + 1);
  localparam int unsigned NCW = $clog2(MAX_COLS + 1);

  logic [lag_pkg::CFG_W-1:0]  rows_q, cols_q;
  logic [lag_pkg::SIZE_W-1:0] nr_full, nc_full;

  // zero acts as one, anything above the grid acts as the grid size
  function automatic logic [lag_pkg::SIZE_W-1:0] clamp_size(
    input logic [lag_pkg::CFG_W-1:0]  v,
    input logic [lag_pkg::SIZE_W-1:0] maxv
  );
    logic [lag_pkg::SIZE_W-1:0] ext;
    ext = lag_pkg::SIZE_W'(v);
    priority if (ext == '0) begin
      return lag_pkg::SIZE_W'(1);
    end else if (ext > maxv) begin
      return maxv;
    end else begin
      return ext;
    end
  endfunction

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= lag_pkg::CFG_SIZE_RESET;
      cols_q <= lag_pkg::CFG_SIZE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        lag_pkg::CFG_ROWS: rows_q <= cfg_data_i;
        lag_pkg::CFG_COLS: cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign nr_full = clamp_size(rows_q, lag_pkg::SIZE_W'(MAX_ROWS));
  assign nc_full = clamp_size(cols_q, lag_pkg::SIZE_W'(MAX_COLS));
  assign nr_o    = nr_full[NRW-1:0];
  assign nc_o    = nc_full[NCW-1:0];

endmodule

/* src/lag_ctrl.sv */
// Controller: beat acceptance, read handoff and the generation row sequencer.
module lag_ctrl #(
  parameter int unsigned MAX_ROWS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [lag_pkg::OP_W-1:0]       opcode_i,
  input  logic [$clog2(MAX_ROWS+1)-1:0]  nr_i,
  input  lag_pkg::sts_t                  sts_i,
  output lag_pkg::cmd_t                  cmd_o,
  output logic [$clog2(MAX_ROWS)-1:0]    gen_rd_row_o,
  output logic [$clog2(MAX_ROWS)-1:0]    gen_wr_row_o
);

  localparam int unsigned RW  = $clog2(MAX_ROWS);
  localparam int unsigned NRW = $clog2(MAX_ROWS + 1);
  localparam int unsigned SW  = $clog2(MAX_ROWS + 2);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_GEN  = 3'b100
  } state_e;

  state_e          state_q, state_d;
  logic [SW-1:0]   step_q, step_d;
  logic [SW-1:0]   nr_ext, step_m2;
  logic            accept;

  assign nr_ext       = SW'(nr_i);
  assign step_m2      = step_q - SW'(2);
  assign gen_rd_row_o = step_q[RW-1:0];
  assign gen_wr_row_o = step_m2[RW-1:0];
  assign in_stall_o   = (state_q != ST_IDLE);
  assign accept       = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (opcode_i)
            lag_pkg::OP_WRITE: cmd_o.cell_we = 1'b1;
            lag_pkg::OP_READ: begin
              cmd_o.cell_re = 1'b1;
              state_d       = ST_READ;
            end
            lag_pkg::OP_GEN: begin
              cmd_o.gen_start = 1'b1;
              step_d          = '0;
              state_d         = ST_GEN;
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_GEN: begin
        // step s reads row s, consumes row s-1, writes row s-2
        cmd_o.gen_shift = 1'b1;
        cmd_o.gen_re    = (step_q < nr_ext);
        cmd_o.gen_use   = (step_q != '0) && (step_q <= nr_ext);
        cmd_o.gen_we    = (step_q >= SW'(2));
        if (step_q == nr_ext + SW'(1)) begin
          cmd_o.flip = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          step_d = step_q + SW'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  a_wr_row_in_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.gen_we |-> (NRW'(gen_wr_row_o) < nr_i))
    else $error("generation write outside region");

  a_out_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> sts_i.out_free)
    else $error("read result loaded into a full output register");

  a_flip_after_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.flip |-> (cmd_o.gen_we && !cmd_o.gen_re))
    else $error("bank flip without last row write");

  a_idle_after_flip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.flip |=> !in_stall_o)
    else $error("not ready after generation");

endmodule

/* src/lag_dp.sv */
// Datapath: two row-wide grid banks, row window with cell lanes, output register.
module lag_dp #(
  parameter int unsigned MAX_ROWS = 32,
  parameter int unsigned MAX_COLS = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  lag_pkg::cmd_t                    cmd_i,
  output lag_pkg::sts_t                    sts_o,
  input  logic [$clog2(MAX_ROWS)-1:0]      gen_rd_row_i,
  input  logic [$clog2(MAX_ROWS)-1:0]      gen_wr_row_i,
  input  logic [$clog2(MAX_COLS+1)-1:0]    nc_i,
  input  logic [lag_pkg::ADDR_W-1:0]       row_i,
  input  logic [lag_pkg::ADDR_W-1:0]       col_i,
  input  logic                             cell_in_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             cell_out_o
);

  localparam int unsigned RW  = $clog2(MAX_ROWS);
  localparam int unsigned CLW = $clog2(MAX_COLS);
  localparam int unsigned NCW = $clog2(MAX_COLS + 1);

  logic                        act_q;
  logic [lag_pkg::SIZE_W-1:0]  row_ext, col_ext;
  logic                        in_grid;
  logic [RW-1:0]               row_a;
  logic [CLW-1:0]              col_a;
  logic [MAX_COLS-1:0]         one_word;
  logic [MAX_COLS-1:0]         colmask;
  logic [MAX_COLS-1:0]         rd_eff [2];
  logic [MAX_COLS-1:0]         rdat, next_row, new_row;
  logic [MAX_COLS-1:0]         above_q, cur_q;
  logic [MAX_COLS+1:0]         apad, cpad, npad;
  logic                        rd_inside_q;
  logic [CLW-1:0]              rd_col_q;
  logic                        out_valid_q, cell_q;

  // B3/S23 on the eight neighbor bits
  function automatic logic life_rule(input logic [7:0] nb, input logic alive);
    logic [3:0] cnt;
    cnt = '0;
    for (int i = 0; i < 8; i++) begin
      cnt = cnt + 4'(nb[i]);
    end
    return (cnt == 4'd3) || ((cnt == 4'd2) && alive);
  endfunction

  assign row_ext  = lag_pkg::SIZE_W'(row_i);
  assign col_ext  = lag_pkg::SIZE_W'(col_i);
  assign in_grid  = (row_ext < lag_pkg::SIZE_W'(MAX_ROWS)) &&
                    (col_ext < lag_pkg::SIZE_W'(MAX_COLS));
  assign row_a    = row_ext[RW-1:0];
  assign col_a    = col_ext[CLW-1:0];
  assign one_word = MAX_COLS'(cell_in_i) << col_a;

  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      colmask[c] = (NCW'(c) < nc_i);
    end
  end

  for (genvar b = 0; b < 2; b++) begin : g_bank
    logic [MAX_COLS-1:0] mem [MAX_ROWS];
    logic [MAX_ROWS-1:0] vld_q;  // row not valid reads as all dead
    logic [MAX_COLS-1:0] rd_q;
    logic                rvld_q;
    logic                is_act, cell_we, gen_we, re;
    logic [RW-1:0]       raddr;

    assign is_act  = (act_q == 1'(b));
    assign cell_we = cmd_i.cell_we && in_grid && is_act;
    assign gen_we  = cmd_i.gen_we && !is_act;
    assign re      = (cmd_i.cell_re || cmd_i.gen_re) && is_act;
    assign raddr   = cmd_i.cell_re ? row_a : gen_rd_row_i;

    always_ff @(posedge clk_i) begin
      if (cell_we) begin
        if (vld_q[row_a]) begin
          mem[row_a][col_a] <= cell_in_i;
        end else begin
          mem[row_a] <= one_word;
        end
      end else if (gen_we) begin
        mem[gen_wr_row_i] <= new_row;
      end
      if (re) begin
        rd_q   <= mem[raddr];
        rvld_q <= vld_q[raddr];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q <= '0;
      end else if (cmd_i.gen_start && !is_act) begin
        vld_q <= '0;
      end else if (cell_we) begin
        vld_q[row_a] <= 1'b1;
      end else if (gen_we) begin
        vld_q[gen_wr_row_i] <= 1'b1;
      end
    end

    assign rd_eff[b] = rvld_q ? rd_q : '0;
  end

  assign rdat     = act_q ? rd_eff[1] : rd_eff[0];
  assign next_row = cmd_i.gen_use ? (rdat & colmask) : '0;

  assign apad = {1'b0, above_q, 1'b0};
  assign cpad = {1'b0, cur_q, 1'b0};
  assign npad = {1'b0, next_row, 1'b0};

  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      new_row[c] = colmask[c] &&
                   life_rule({apad[c], apad[c+1], apad[c+2], cpad[c], cpad[c+2],
                              npad[c], npad[c+1], npad[c+2]}, cpad[c+1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.gen_start) begin
      above_q <= '0;
      cur_q   <= '0;
    end else if (cmd_i.gen_shift) begin
      above_q <= cur_q;
      cur_q   <= next_row;
    end
    if (cmd_i.cell_re) begin
      rd_inside_q <= in_grid;
      rd_col_q    <= col_a;
    end
    if (cmd_i.out_load) begin
      cell_q <= rd_inside_q && rdat[rd_col_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.flip) begin
        act_q <= ~act_q;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o    = out_valid_q;
  assign cell_out_o     = cell_q;

endmodule
